>>> hw/rtl/sfv_pkg.sv
// Shared constants, types and codes for the sparse FFT location vote block.
`default_nettype none

package sfv_pkg;

    // Spectrum and bucket geometry
    localparam int SPEC_SIZE  = 8192;
    localparam int BUCKETS    = 128;
    localparam int LOC_W      = $clog2(SPEC_SIZE);
    localparam int BUCKET_W   = SPEC_SIZE / BUCKETS;
    localparam int HALF_W     = BUCKET_W / 2;
    localparam int WALK_CNT_W = (BUCKET_W > 1) ? $clog2(BUCKET_W) : 1;

    // Field widths fixed by the item formats
    localparam int BIN_W    = 7;
    localparam int MULT_W   = 13;
    localparam int COUNT_W  = 4;
    localparam int TOTAL_W  = 14;
    localparam int NUMBER_W = 13;
    localparam int HITLOC_W = 13;

    localparam logic [COUNT_W-1:0] COUNT_SAT  = '1;
    localparam logic [COUNT_W-1:0] THR_RESET  = 4'd6;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT  = '1;

    // Action codes of an input item
    localparam logic ACTION_VOTE  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN
    } sfv_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load_item;
        logic             setup;
        logic             issue;
        logic             clear_wr;
        logic [LOC_W-1:0] clear_addr;
        logic             flush;
    } sfv_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic stall;
        logic m_busy;
        logic pend_valid;
        logic out_free;
    } sfv_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfv_vote_if.sv
// Input channel carrying vote and clear items.
`default_nettype none

interface sfv_vote_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [sfv_pkg::BIN_W-1:0]   bin_index;
    logic [sfv_pkg::MULT_W-1:0]  multiplier;

    modport source (output valid, output action, output bin_index, output multiplier,
                    input ready);
    modport sink (input valid, input action, input bin_index, input multiplier,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sfv_hit_if.sv
// Output channel carrying hit items.
`default_nettype none

interface sfv_hit_if;
    logic                          valid;
    logic                          ready;
    logic [sfv_pkg::HITLOC_W-1:0]  hit_location;
    logic [sfv_pkg::NUMBER_W-1:0]  hit_number;
    logic                          last_in_run;

    modport source (output valid, output hit_location, output hit_number,
                    output last_in_run, input ready);
    modport sink (input valid, input hit_location, input hit_number,
                  input last_in_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sfv_datapath.sv
// Datapath: vote memory, location walk, read-modify-write pipe and hit output.
`default_nettype none

module sfv_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sfv_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire sfv_pkg::sfv_cmd_t             cmd,
    output sfv_pkg::sfv_status_t               status,
    input  wire logic [sfv_pkg::BIN_W-1:0]     bin_index,
    input  wire logic [sfv_pkg::MULT_W-1:0]    multiplier,
    sfv_hit_if.source                          hit
);

    localparam int LOC_W = sfv_pkg::LOC_W;
    localparam int CW    = sfv_pkg::COUNT_W;

    // Vote count memory, no reset: cleared by a sweep
    logic [CW-1:0] vote_mem [sfv_pkg::SPEC_SIZE];

    logic [CW-1:0]                 threshold_reg;
    logic [sfv_pkg::BIN_W-1:0]     bin_reg;
    logic [LOC_W-1:0]              mult_reg;
    logic [LOC_W-1:0]              loc_reg;

    logic                          m_valid_reg;
    logic [LOC_W-1:0]              m_loc_reg;
    logic [CW-1:0]                 rd_data_reg;

    logic                          wr_valid_reg;
    logic [LOC_W-1:0]              wr_loc_reg;
    logic [CW-1:0]                 wr_cnt_reg;

    logic                          pend_valid_reg;
    logic [LOC_W-1:0]              pend_loc_reg;
    logic [sfv_pkg::NUMBER_W-1:0]  pend_num_reg;

    logic                          out_valid_reg;
    logic [LOC_W-1:0]              out_loc_reg;
    logic [sfv_pkg::NUMBER_W-1:0]  out_num_reg;
    logic                          out_last_reg;

    logic [sfv_pkg::TOTAL_W-1:0]   total_reg;

    logic [LOC_W-1:0]              bin_scaled;
    logic [LOC_W-1:0]              start_loc;
    logic [2*LOC_W-1:0]            start_prod;
    logic [CW-1:0]                 cur_cnt;
    logic [CW-1:0]                 new_cnt;
    logic                          cnt_sat;
    logic                          m_hit;
    logic                          out_free;
    logic                          stall;
    logic                          advance;
    logic                          step;
    logic                          hit_take;
    logic                          push_out;
    logic                          rd_en;
    logic                          mem_we;
    logic [LOC_W-1:0]              mem_addr;
    logic [CW-1:0]                 mem_wdata;

    // First location of the walk: bucket start times the multiplier, mod N
    assign bin_scaled = LOC_W'(bin_reg) * LOC_W'(sfv_pkg::BUCKET_W);
    assign start_loc  = bin_scaled - LOC_W'(sfv_pkg::HALF_W);
    assign start_prod = start_loc * mult_reg;

    // Count seen by the modify stage, forwarded from the write of the previous location
    assign cur_cnt  = (wr_valid_reg && (wr_loc_reg == m_loc_reg)) ? wr_cnt_reg : rd_data_reg;
    assign cnt_sat  = (cur_cnt == sfv_pkg::COUNT_SAT);
    assign new_cnt  = cnt_sat ? cur_cnt : cur_cnt + CW'(1);
    assign m_hit    = m_valid_reg && !cnt_sat && (new_cnt == threshold_reg);

    // The pipe freezes when a hit needs the pending slot and the output is still full
    assign out_free = !out_valid_reg || hit.ready;
    assign stall    = m_hit && pend_valid_reg && !out_free;
    assign advance  = !stall;
    assign step     = advance && m_valid_reg;
    assign hit_take = step && m_hit;
    assign push_out = (hit_take && pend_valid_reg) || cmd.flush;
    assign rd_en    = cmd.issue && advance;

    // Memory write port shared by the clearing sweep and the vote update
    assign mem_we    = step || cmd.clear_wr;
    assign mem_addr  = cmd.clear_wr ? cmd.clear_addr : m_loc_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : new_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vote_mem[mem_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= vote_mem[loc_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= sfv_pkg::THR_RESET;
            m_valid_reg    <= 1'b0;
            wr_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                m_valid_reg  <= cmd.issue;
                wr_valid_reg <= m_valid_reg;
            end
            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (hit_take)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hit.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear_wr)
            begin
                total_reg <= '0;
            end
            else if (hit_take && (total_reg != sfv_pkg::TOTAL_SAT))
            begin
                total_reg <= total_reg + sfv_pkg::TOTAL_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            bin_reg  <= bin_index;
            mult_reg <= LOC_W'(multiplier);
        end
        if (cmd.setup)
        begin
            loc_reg <= start_prod[LOC_W-1:0];
        end
        else if (rd_en)
        begin
            loc_reg <= loc_reg + mult_reg;
        end
        if (rd_en)
        begin
            m_loc_reg <= loc_reg;
        end
        if (step)
        begin
            wr_loc_reg <= m_loc_reg;
            wr_cnt_reg <= new_cnt;
        end
        if (hit_take)
        begin
            pend_loc_reg <= m_loc_reg;
            pend_num_reg <= total_reg[sfv_pkg::NUMBER_W-1:0];
        end
        if (push_out)
        begin
            out_loc_reg  <= pend_loc_reg;
            out_num_reg  <= pend_num_reg;
            out_last_reg <= cmd.flush;
        end
    end

    // Status and output channel
    assign status.stall      = stall;
    assign status.m_busy     = m_valid_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign hit.valid        = out_valid_reg;
    assign hit.hit_location = sfv_pkg::HITLOC_W'(out_loc_reg);
    assign hit.hit_number   = out_num_reg;
    assign hit.last_in_run  = out_last_reg;

    // A hit cannot overwrite a held output item
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push_out |-> out_free)
        else $error("hit output overwritten while still held");

    // The hit total only moves by one per taken hit unless cleared
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.clear_wr && !hit_take) |=> (total_reg == $past(total_reg)))
        else $error("hit total changed without a hit");

    // A frozen pipe keeps its modify stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (m_valid_reg && (m_loc_reg == $past(m_loc_reg))))
        else $error("modify stage lost during a stall");

endmodule

`default_nettype wire

>>> hw/rtl/sfv_ctrl.sv
// Controller: sequences clearing sweeps, walk setup, the location walk and the final flush.
`default_nettype none

module sfv_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vote_valid,
    input  wire logic                  vote_action,
    output logic                       vote_ready,
    input  wire sfv_pkg::sfv_status_t  status,
    output sfv_pkg::sfv_cmd_t          cmd
);

    localparam int LOC_W = sfv_pkg::LOC_W;
    localparam int WCW   = sfv_pkg::WALK_CNT_W;

    sfv_pkg::sfv_state_t state_reg;
    sfv_pkg::sfv_state_t state_next;
    logic [LOC_W-1:0]    sweep_reg;
    logic [LOC_W-1:0]    sweep_next;
    logic [WCW-1:0]      walk_cnt_reg;
    logic [WCW-1:0]      walk_cnt_next;

    // State register; reset starts with a clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sfv_pkg::ST_CLEAR;
            sweep_reg    <= '0;
            walk_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            walk_cnt_reg <= walk_cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        walk_cnt_next  = walk_cnt_reg;
        vote_ready     = 1'b0;
        cmd            = '0;
        cmd.clear_addr = sweep_reg;

        unique case (state_reg)
            sfv_pkg::ST_IDLE:
            begin
                vote_ready = 1'b1;
                if (vote_valid)
                begin
                    if (vote_action == sfv_pkg::ACTION_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = sfv_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = sfv_pkg::ST_SETUP;
                    end
                end
            end
            sfv_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                sweep_next   = sweep_reg + LOC_W'(1);
                if (sweep_reg == LOC_W'(sfv_pkg::SPEC_SIZE - 1))
                begin
                    state_next = sfv_pkg::ST_IDLE;
                end
            end
            sfv_pkg::ST_SETUP:
            begin
                cmd.setup     = 1'b1;
                walk_cnt_next = '0;
                state_next    = sfv_pkg::ST_WALK;
            end
            sfv_pkg::ST_WALK:
            begin
                cmd.issue = 1'b1;
                if (!status.stall)
                begin
                    walk_cnt_next = walk_cnt_reg + WCW'(1);
                    if (walk_cnt_reg == WCW'(sfv_pkg::BUCKET_W - 1))
                    begin
                        state_next = sfv_pkg::ST_DRAIN;
                    end
                end
            end
            sfv_pkg::ST_DRAIN:
            begin
                // Wait for the last location to retire, then release the held hit as last
                if (!status.m_busy)
                begin
                    if (!status.pend_valid)
                    begin
                        state_next = sfv_pkg::ST_IDLE;
                    end
                    else if (status.out_free)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = sfv_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sfv_pkg::ST_IDLE;
            end
        endcase
    end

    // Between items the pipe and the pending hit are empty
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfv_pkg::ST_IDLE) |-> (!status.m_busy && !status.pend_valid))
        else $error("idle with work still in the datapath");

    // The final hit is only released into a free output
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (status.out_free && status.pend_valid))
        else $error("flush without a pending hit or a free output");

    // A stalled walk does not advance its counter
    a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sfv_pkg::ST_WALK) && status.stall) |=>
            (walk_cnt_reg == $past(walk_cnt_reg)))
        else $error("walk counter moved during a stall");

endmodule

`default_nettype wire

>>> hw/rtl/sparse_fft_location_vote_top.sv
// Top level of the sparse FFT location vote block.
// A vote item walks the 64 permuted locations of one bucket with one read-modify-write of
// the 8192-entry vote count memory per location, in order: the item is loaded, the first
// location is formed with a single multiply, the locations are walked, and the last location
// retires and the last hit is released. The walk pauses when a new hit is found while a hit
// is waiting and the output item is not taken. Hits leave in walk order, each after the next
// hit of the same item is found, and the last one is marked. A clear item, and the start
// after reset, runs a clearing pass over the whole vote memory during which no item
// is accepted; threshold writes are taken at any time. Vote and clear items are accepted
// only when the block is idle, but a finished hit item may still wait at the output.
`default_nettype none

module sparse_fft_location_vote_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sfv_pkg::COUNT_W-1:0]  cfg_wr_data,
    sfv_vote_if.sink                          vote,
    sfv_hit_if.source                         hit
);

    sfv_pkg::sfv_cmd_t    cmd;
    sfv_pkg::sfv_status_t status;

    // Sequencer
    sfv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .vote_valid  (vote.valid),
        .vote_action (vote.action),
        .vote_ready  (vote.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Vote memory, walk pipe and hit output
    sfv_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .bin_index   (vote.bin_index),
        .multiplier  (vote.multiplier),
        .hit         (hit)
    );

endmodule

`default_nettype wire

>>> bench/sfv_vote_checker.sv
// Checker that predicts the hit items of the location vote block and compares them.
`timescale 1ns / 100ps

module sfv_vote_checker
    import sfv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    sfv_vote_if                 vote,
    sfv_hit_if                  hit,
    output int                  mismatches,
    output int                  hits_outstanding
);

    typedef struct packed {
        logic [HITLOC_W-1:0] location;
        logic [NUMBER_W-1:0] number;
        logic                last_in_run;
    } hit_rec_t;

    // Shadow copy of the vote memory, the hit total and the threshold
    logic [COUNT_W-1:0] vote_tally [SPEC_SIZE];
    logic [TOTAL_W-1:0] hit_total;
    logic [COUNT_W-1:0] threshold;
    hit_rec_t           expected_hits [$];
    int                 error_count;

    task automatic wipe_votes();
        foreach (vote_tally[i])
            vote_tally[i] = '0;
        hit_total = '0;
    endtask

    // Walk the permuted window of one bucket and queue the hits it makes.
    task automatic cast_votes(input logic [BIN_W-1:0] bin, input logic [MULT_W-1:0] mult);
        logic [LOC_W-1:0]   loc;
        logic [COUNT_W-1:0] tally;
        hit_rec_t           rec;
        int                 found;

        loc   = LOC_W'(int'(bin) * BUCKET_W - HALF_W);
        loc   = loc * mult;
        found = 0;
        repeat (BUCKET_W)
        begin
            tally = vote_tally[loc];
            // A saturated count never moves, so it never reports again.
            if (tally != COUNT_SAT)
            begin
                tally           = tally + 1'b1;
                vote_tally[loc] = tally;
                if (tally == threshold)
                begin
                    rec.location    = loc;
                    rec.number      = hit_total[NUMBER_W-1:0];
                    rec.last_in_run = 1'b0;
                    expected_hits.push_back(rec);
                    found++;
                    if (hit_total != TOTAL_SAT)
                        hit_total = hit_total + 1'b1;
                end
            end
            loc = loc + mult;
        end
        if (found > 0)
            expected_hits[expected_hits.size() - 1].last_in_run = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_rec_t want;
        if (!rst_n)
        begin
            wipe_votes();
            threshold = THR_RESET;
            expected_hits.delete();
            error_count = 0;
        end
        else
        begin
            // Each accepted hit item is matched against the oldest expectation.
            if (hit.valid && hit.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    error_count++;
                    $display("%0t: hit item with nothing expected: loc=%0d num=%0d last=%0b",
                             $time, hit.hit_location, hit.hit_number, hit.last_in_run);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit.hit_location !== want.location || hit.hit_number !== want.number ||
                        hit.last_in_run !== want.last_in_run)
                    begin
                        error_count++;
                        $display("%0t: hit mismatch: expected loc=%0d num=%0d last=%0b, got loc=%0d num=%0d last=%0b",
                                 $time, want.location, want.number, want.last_in_run,
                                 hit.hit_location, hit.hit_number, hit.last_in_run);
                    end
                end
            end

            // Threshold writes take effect for the items that follow.
            if (cfg_wr_en)
                threshold = cfg_wr_data;

            // Every accepted input item updates the shadow state.
            if (vote.valid && vote.ready)
            begin
                if (vote.action == ACTION_CLEAR)
                    wipe_votes();
                else
                    cast_votes(vote.bin_index, vote.multiplier);
            end
        end
        mismatches       <= error_count;
        hits_outstanding <= expected_hits.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the testbench: clock, reset, item stimulus and verdict for the location vote block.
`timescale 1ns / 100ps

module testbench;
    import sfv_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RUNS_PER_LEG = 3;
    localparam int RUN_ITEMS    = 40;
    localparam int TONES        = 4;
    localparam int WALK_SLACK   = 100;   // margin for a vote walk to finish
    localparam int HOLD_CYCLES  = 800;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    sfv_vote_if vote_ch ();
    sfv_hit_if  hit_ch ();

    int                mismatches;
    int                hits_outstanding;
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                pressure_armed;
    logic              last_action;
    logic [BIN_W-1:0]  last_bin;
    logic [MULT_W-1:0] last_mult;

    sparse_fft_location_vote_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .vote        (vote_ch),
        .hit         (hit_ch)
    );

    sfv_vote_checker vote_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .vote             (vote_ch),
        .hit              (hit_ch),
        .mismatches       (mismatches),
        .hits_outstanding (hits_outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #40_000_000;
        $display("sparse_fft_location_vote_top verification failed");
        $finish;
    end

    // Offer one item after a random gap and hold it until the block takes it.
    task automatic send_item(input logic act, input logic [BIN_W-1:0] bin,
                             input logic [MULT_W-1:0] mult);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vote_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vote_ch.valid      <= 1'b1;
        vote_ch.action     <= act;
        vote_ch.bin_index  <= bin;
        vote_ch.multiplier <= mult;
        @(posedge clk);
        while (!vote_ch.ready)
            @(posedge clk);
        last_action = act;
        if (act == ACTION_VOTE)
        begin
            last_bin  = bin;
            last_mult = mult;
        end
    endtask

    // Wait until every hit is out and the last walk or clearing pass is over.
    task automatic settle();
        vote_ch.valid <= 1'b0;
        @(posedge clk);
        while (hits_outstanding != 0)
            @(posedge clk);
        repeat ((last_action == ACTION_CLEAR) ? SPEC_SIZE + WALK_SLACK : WALK_SLACK)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Bucket that holds a given tone once the spectrum is permuted by an odd multiplier.
    function automatic logic [BIN_W-1:0] bucket_of(input logic [LOC_W-1:0] tone,
                                                   input logic [MULT_W-1:0] mult);
        logic [LOC_W-1:0] inv;
        logic [LOC_W-1:0] pos;
        inv = mult;
        repeat (4)
            inv = inv * (LOC_W'(2) - mult * inv);
        pos = tone * inv + LOC_W'(HALF_W);
        return pos[LOC_W-1 -: BIN_W];
    endfunction

    // Output side: random stalls, plus one long hold-off once pressure is armed.
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        hit_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed && !held_off && hit_ch.valid)
            begin
                hit_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                held_off = 1'b1;
            end
            hit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Input side: reset, directed items, then random voting rounds.
    initial
    begin
        logic [LOC_W-1:0]   tones [TONES];
        logic [MULT_W-1:0]  round_mult;
        logic [COUNT_W-1:0] thr;
        int                 tone_idx;
        int                 pick;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        vote_ch.valid      <= 1'b0;
        vote_ch.action     <= ACTION_VOTE;
        vote_ch.bin_index  <= '0;
        vote_ch.multiplier <= '0;
        send_idle_pct  = 27;
        recv_idle_pct  = 80;
        pressure_armed = 1'b0;
        last_action    = ACTION_VOTE;
        last_bin       = '0;
        last_mult      = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Threshold at its reset value: the sixth vote on one window reports all of it.
        repeat (6)
            send_item(ACTION_VOTE, 7'd1, 13'd1);
        settle();

        // Threshold one: field extremes, a repeated window, a clear and a non-coprime step.
        write_threshold(4'd1);
        send_item(ACTION_VOTE, 7'd0, 13'd1);
        send_item(ACTION_VOTE, 7'd127, 13'd8191);
        send_item(ACTION_VOTE, 7'd0, 13'd1);
        send_item(ACTION_VOTE, 7'd85, 13'h1555);
        send_item(ACTION_VOTE, 7'd42, 13'h0AAA);
        send_item(ACTION_CLEAR, 7'd127, 13'h1FFF);
        send_item(ACTION_VOTE, 7'd0, 13'd1);
        send_item(ACTION_VOTE, 7'd64, 13'd4096);
        settle();

        // Threshold fifteen: a zero multiplier piles every vote on one location.
        write_threshold(4'd15);
        send_item(ACTION_VOTE, 7'd5, 13'd0);
        send_item(ACTION_VOTE, 7'd5, 13'd0);
        send_item(ACTION_VOTE, 7'd100, 13'd4096);
        settle();

        // Threshold zero can never be met.
        write_threshold(4'd0);
        send_item(ACTION_VOTE, 7'd0, 13'd1);
        send_item(ACTION_VOTE, 7'd127, 13'd8191);

        // Voting rounds: a few tones seen through a fresh odd multiplier each round,
        // mixed with repeated windows, random noise and the odd clear.
        for (int leg = 0; leg < 3; leg++)
        begin
            send_idle_pct = (leg == 0) ? 27 : (leg == 1) ? 80 : 0;
            recv_idle_pct = (leg == 0) ? 80 : (leg == 1) ? 27 : 0;
            for (int run = 0; run < RUNS_PER_LEG; run++)
            begin
                settle();
                pick = $urandom_range(99);
                if ((leg == 2 && run == 0) || pick < 15)
                    thr = 4'd1;
                else if (pick < 30)
                    thr = 4'd15;
                else
                    thr = COUNT_W'($urandom_range(14, 2));
                write_threshold(thr);
                if (leg == 2 && run == 0)
                    pressure_armed = 1'b1;

                foreach (tones[t])
                    tones[t] = LOC_W'($urandom);
                tone_idx   = 0;
                round_mult = MULT_W'($urandom) | 1'b1;
                if ($urandom_range(99) < 40)
                    send_item(ACTION_CLEAR, BIN_W'($urandom), MULT_W'($urandom));

                repeat (RUN_ITEMS)
                begin
                    pick = $urandom_range(99);
                    if (pick < 65)
                    begin
                        send_item(ACTION_VOTE, bucket_of(tones[tone_idx], round_mult),
                                  round_mult);
                        tone_idx++;
                        if (tone_idx == TONES)
                        begin
                            tone_idx   = 0;
                            round_mult = MULT_W'($urandom) | 1'b1;
                        end
                    end
                    else if (pick < 85)
                        send_item(ACTION_VOTE, last_bin, last_mult);
                    else if (pick < 99)
                        send_item(ACTION_VOTE, BIN_W'($urandom), MULT_W'($urandom));
                    else
                        send_item(ACTION_CLEAR, BIN_W'($urandom), MULT_W'($urandom));
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("sparse_fft_location_vote_top verification clean");
        else
            $display("sparse_fft_location_vote_top verification failed");
        $finish;
    end

endmodule
